>>> rtl/disc_ring_row_span_top_defines.svh
// Assertion macros shared by the row span block.
`ifndef DISC_RING_ROW_SPAN_TOP_DEFINES_SVH
`define DISC_RING_ROW_SPAN_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define DRP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("row span check failed");

// Check that cons holds in the cycle after ante.
`define DRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("row span check failed");

`endif

>>> rtl/drp_pkg.sv
// Shared types and constants of the row span block.
`timescale 1ns / 1ps
package drp_pkg;

  localparam int COORD_W  = 16;
  localparam int RADIUS_W = 10;
  localparam int OFFSET_W = 11;
  localparam int WIDTH_W  = 11;

  // Number of spans a finished row yields.
  typedef enum logic [1:0] {
    SPN_NONE = 2'd0,
    SPN_ONE  = 2'd1,
    SPN_TWO  = 2'd2
  } span_cnt_t;

  typedef struct packed {
    span_cnt_t            cnt;
    logic [COORD_W-1:0]   x_left;
    logic [COORD_W-1:0]   x_right;
    logic [COORD_W-1:0]   y;
    logic [WIDTH_W-1:0]   width;
  } row_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

>>> rtl/drp_sqrt.sv
// Pipelined floor square root, two result bits per stage.
`timescale 1ns / 1ps
module drp_sqrt #(
  parameter int OUT_W = 10
) (
  input  logic               clk,
  input  logic [2*OUT_W-1:0] op,
  output logic [OUT_W-1:0]   root
);
  localparam int IN_W   = 2 * OUT_W;
  localparam int W      = IN_W + 1;
  localparam int STEPS  = 2;
  localparam int STAGES = (OUT_W + STEPS - 1) / STEPS;

  logic [W-1:0] rem_r [STAGES];
  logic [W-1:0] res_r [STAGES];
  logic [W-1:0] rem_src [STAGES];
  logic [W-1:0] res_src [STAGES];
  logic [W-1:0] rem_nxt [STAGES];
  logic [W-1:0] res_nxt [STAGES];

  function automatic logic [W-1:0] bit_at(input int k);
    return W'(1) << (2 * (OUT_W - 1 - k));
  endfunction

  always_comb begin
    rem_src[0] = W'(op);
    res_src[0] = '0;
    for (int s = 1; s < STAGES; s++) begin
      rem_src[s] = rem_r[s-1];
      res_src[s] = res_r[s-1];
    end
  end

  always_comb begin
    logic [W-1:0] rem_v;
    logic [W-1:0] res_v;
    logic [W-1:0] trial;
    for (int s = 0; s < STAGES; s++) begin
      rem_v = rem_src[s];
      res_v = res_src[s];
      for (int j = 0; j < STEPS; j++) begin
        if (s * STEPS + j < OUT_W) begin
          trial = res_v + bit_at(s * STEPS + j);
          if (rem_v >= trial) begin
            rem_v = rem_v - trial;
            res_v = (res_v >> 1) + bit_at(s * STEPS + j);
          end else begin
            res_v = res_v >> 1;
          end
        end
      end
      rem_nxt[s] = rem_v;
      res_nxt[s] = res_v;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < STAGES; s++) begin
      rem_r[s] <= rem_nxt[s];
      res_r[s] <= res_nxt[s];
    end
  end

  assign root = res_r[STAGES-1][OUT_W-1:0];

endmodule

>>> rtl/drp_front.sv
// Front end: accepts rows, squares, classifies and finds half-widths.
`timescale 1ns / 1ps
module drp_front #(
  parameter int RADIUS_BITS = 10
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  logic                                   in_action,
  input  logic signed [drp_pkg::COORD_W-1:0]     in_center_x,
  input  logic signed [drp_pkg::COORD_W-1:0]     in_center_y,
  input  logic        [drp_pkg::RADIUS_W-1:0]    in_radius,
  input  logic        [drp_pkg::RADIUS_W-1:0]    in_thickness,
  input  logic signed [drp_pkg::OFFSET_W-1:0]    in_row_offset,
  input  drp_pkg::queue_stat_t                   q_stat,
  output logic                                   q_alloc,
  output logic                                   q_wr,
  output drp_pkg::row_entry_t                    q_wdata
);
  import drp_pkg::*;

  localparam int RB       = (RADIUS_BITS < RADIUS_W) ? RADIUS_BITS : RADIUS_W;
  localparam int SQ_W     = 2 * RB;
  localparam int D2_W     = 2 * OFFSET_W - 1;
  localparam int TERM_W   = ((SQ_W > D2_W) ? SQ_W : D2_W) + 1;
  localparam int SQRT_LAT = (RB + 1) / 2;

  typedef enum logic [1:0] {
    ROW_DISC,
    ROW_EMPTY,
    ROW_SOLID,
    ROW_SIDES
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] y;
  } side_t;

  logic accept;
  assign in_full = q_stat.full;
  assign accept  = in_push && !q_stat.full;
  assign q_alloc = accept;

  // Stage 1: offsets and absolute values
  logic [RB-1:0]        rad_m;
  logic [RB-1:0]        thk_m;
  logic signed [RB:0]   ri_diff;
  logic [RB-1:0]        ri_abs_nxt;
  logic [OFFSET_W-1:0]  ady_nxt;
  logic [COORD_W-1:0]   y_nxt;

  assign rad_m      = in_radius[RB-1:0];
  assign thk_m      = in_thickness[RB-1:0];
  assign ri_diff    = $signed({1'b0, rad_m}) - $signed({1'b0, thk_m});
  assign ri_abs_nxt = ri_diff[RB] ? RB'(-ri_diff) : ri_diff[RB-1:0];
  assign ady_nxt    = in_row_offset[OFFSET_W-1] ? OFFSET_W'(-in_row_offset)
                                                : in_row_offset;
  assign y_nxt      = in_center_y + COORD_W'(in_row_offset);

  logic                v1_r;
  logic                act1_r;
  logic [COORD_W-1:0]  cx1_r;
  logic [COORD_W-1:0]  y1_r;
  logic [RB-1:0]       rad1_r;
  logic [RB-1:0]       ri1_r;
  logic [OFFSET_W-1:0] ady1_r;

  // Stage 2: squares
  logic [SQ_W-1:0]       r2_nxt;
  logic [SQ_W-1:0]       i2_nxt;
  logic [2*OFFSET_W-1:0] d2_full;

  assign r2_nxt  = rad1_r * rad1_r;
  assign i2_nxt  = ri1_r * ri1_r;
  assign d2_full = ady1_r * ady1_r;

  logic               v2_r;
  logic               act2_r;
  logic [COORD_W-1:0] cx2_r;
  logic [COORD_W-1:0] y2_r;
  logic [SQ_W-1:0]    r2_r;
  logic [SQ_W-1:0]    i2_r;
  logic [D2_W-1:0]    d2_r;

  // Stage 3: terms and classification
  logic signed [TERM_W-1:0] to_w;
  logic signed [TERM_W-1:0] ti_w;
  row_kind_t                kind_nxt;
  logic [SQ_W-1:0]          op_o_nxt;
  logic [SQ_W-1:0]          op_i_nxt;

  assign to_w = $signed(TERM_W'(r2_r)) - $signed(TERM_W'(d2_r));
  assign ti_w = $signed(TERM_W'(i2_r)) - $signed(TERM_W'(d2_r));

  always_comb begin
    op_o_nxt = to_w[SQ_W-1:0];
    op_i_nxt = '0;
    if (!act2_r) begin
      kind_nxt = ROW_DISC;
      if (to_w[TERM_W-1]) begin
        op_o_nxt = '0;
      end
    end else if (to_w[TERM_W-1]) begin
      kind_nxt = ROW_EMPTY;
      op_o_nxt = '0;
    end else if (ti_w[TERM_W-1] || ti_w == '0) begin
      kind_nxt = ROW_SOLID;
    end else begin
      kind_nxt = ROW_SIDES;
      op_i_nxt = ti_w[SQ_W-1:0];
    end
  end

  logic            v3_r;
  side_t           side3_r;
  logic [SQ_W-1:0] op_o_r;
  logic [SQ_W-1:0] op_i_r;

  // Square roots and the matching sideband delay
  logic [RB-1:0] xo;
  logic [RB-1:0] xi;

  drp_sqrt #(.OUT_W(RB)) u_sqrt_outer (
    .clk  (clk),
    .op   (op_o_r),
    .root (xo)
  );

  drp_sqrt #(.OUT_W(RB)) u_sqrt_inner (
    .clk  (clk),
    .op   (op_i_r),
    .root (xi)
  );

  logic  vpipe_r [SQRT_LAT];
  side_t spipe_r [SQRT_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      for (int i = 0; i < SQRT_LAT; i++) begin
        vpipe_r[i] <= 1'b0;
      end
    end else begin
      v1_r       <= accept;
      v2_r       <= v1_r;
      v3_r       <= v2_r;
      vpipe_r[0] <= v3_r;
      for (int i = 1; i < SQRT_LAT; i++) begin
        vpipe_r[i] <= vpipe_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    act1_r       <= in_action;
    cx1_r        <= in_center_x;
    y1_r         <= y_nxt;
    rad1_r       <= rad_m;
    ri1_r        <= ri_abs_nxt;
    ady1_r       <= ady_nxt;
    act2_r       <= act1_r;
    cx2_r        <= cx1_r;
    y2_r         <= y1_r;
    r2_r         <= r2_nxt;
    i2_r         <= i2_nxt;
    d2_r         <= d2_full[D2_W-1:0];
    side3_r.kind <= kind_nxt;
    side3_r.cx   <= cx2_r;
    side3_r.y    <= y2_r;
    op_o_r       <= op_o_nxt;
    op_i_r       <= op_i_nxt;
    spipe_r[0]   <= side3_r;
    for (int i = 1; i < SQRT_LAT; i++) begin
      spipe_r[i] <= spipe_r[i-1];
    end
  end

  // Span geometry for the queue entry
  side_t      side_out;
  logic [RB:0] side_w;

  assign side_out = spipe_r[SQRT_LAT-1];
  assign side_w   = {1'b0, xo} - {1'b0, xi} + 1'b1;
  assign q_wr     = vpipe_r[SQRT_LAT-1];

  always_comb begin
    q_wdata.x_left  = side_out.cx - COORD_W'(xo);
    q_wdata.x_right = side_out.cx + COORD_W'(xi);
    q_wdata.y       = side_out.y;
    q_wdata.width   = WIDTH_W'({xo, 1'b1});
    q_wdata.cnt     = SPN_NONE;
    case (side_out.kind)
      ROW_DISC, ROW_SOLID: begin
        q_wdata.cnt = SPN_ONE;
      end
      ROW_SIDES: begin
        q_wdata.width = WIDTH_W'(side_w);
        // drop the row when the inner half-width passes the outer one
        q_wdata.cnt   = (xi > xo) ? SPN_NONE : SPN_TWO;
      end
      default: begin
        q_wdata.cnt = SPN_NONE;
      end
    endcase
  end

endmodule

>>> rtl/drp_queue.sv
// Row queue between front and back, with slots reserved at accept.
`timescale 1ns / 1ps
module drp_queue #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 alloc,
  input  logic                 wr,
  input  drp_pkg::row_entry_t  wdata,
  input  logic                 pop,
  output drp_pkg::row_entry_t  rdata,
  output drp_pkg::queue_stat_t stat
);
  import drp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  row_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] resv_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] resv_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    resv_nxt   = resv_r;
    if (wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr && pop) begin
      count_nxt = count_r - 1'b1;
    end
    // a slot is held from accept until the back end retires the row
    if (alloc && !pop) begin
      resv_nxt = resv_r + 1'b1;
    end else if (!alloc && pop) begin
      resv_nxt = resv_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      resv_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      resv_r   <= resv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.full  = (resv_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

>>> rtl/drp_back.sv
// Back end: splits queued rows into spans behind an output register.
`timescale 1ns / 1ps
module drp_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  drp_pkg::queue_stat_t               q_stat,
  input  drp_pkg::row_entry_t                q_rdata,
  output logic                               q_pop,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [drp_pkg::COORD_W-1:0]        out_span_x,
  output logic [drp_pkg::COORD_W-1:0]        out_span_y,
  output logic [drp_pkg::WIDTH_W-1:0]        out_span_width,
  output logic                               out_last
);
  import drp_pkg::*;

  logic               out_vld_r;
  logic               half_r;
  logic [COORD_W-1:0] span_x_r;
  logic [COORD_W-1:0] span_y_r;
  logic [WIDTH_W-1:0] width_r;
  logic               last_r;

  logic               out_vld_nxt;
  logic               half_nxt;
  logic [COORD_W-1:0] span_x_nxt;
  logic [COORD_W-1:0] span_y_nxt;
  logic [WIDTH_W-1:0] width_nxt;
  logic               last_nxt;
  logic               out_free;

  assign out_free = !out_vld_r || out_pop;

  always_comb begin
    out_vld_nxt = out_vld_r && !out_pop;
    half_nxt    = half_r;
    span_x_nxt  = span_x_r;
    span_y_nxt  = span_y_r;
    width_nxt   = width_r;
    last_nxt    = last_r;
    q_pop       = 1'b0;
    if (out_free && !q_stat.empty) begin
      span_y_nxt = q_rdata.y;
      width_nxt  = q_rdata.width;
      case (q_rdata.cnt)
        SPN_ONE: begin
          out_vld_nxt = 1'b1;
          span_x_nxt  = q_rdata.x_left;
          last_nxt    = 1'b1;
          q_pop       = 1'b1;
        end
        SPN_TWO: begin
          out_vld_nxt = 1'b1;
          if (!half_r) begin
            // hold the row for its right span
            span_x_nxt = q_rdata.x_left;
            last_nxt   = 1'b0;
            half_nxt   = 1'b1;
          end else begin
            span_x_nxt = q_rdata.x_right;
            last_nxt   = 1'b1;
            half_nxt   = 1'b0;
            q_pop      = 1'b1;
          end
        end
        default: begin
          // drop a row without spans
          q_pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      half_r    <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      half_r    <= half_nxt;
    end
    span_x_r <= span_x_nxt;
    span_y_r <= span_y_nxt;
    width_r  <= width_nxt;
    last_r   <= last_nxt;
  end

  assign out_empty      = !out_vld_r;
  assign out_span_x     = span_x_r;
  assign out_span_y     = span_y_r;
  assign out_span_width = width_r;
  assign out_last       = last_r;

endmodule

>>> rtl/disc_ring_row_span_top.sv
// Top level of the disc and ring row span generator.
`timescale 1ns / 1ps
// Each pushed item describes one row of a filled disc (action 0) or a ring
// (action 1); the block pops out zero, one or two spans for it, the last one
// flagged. A disc row always gives one span; a ring row gives none, one solid
// span, or a left and a right span. Rows flow through a front pipeline (abs and
// subtract, three squarers, classification, then two floor square root
// pipelines of (R+1)/2 stages, R = min(RADIUS_BITS, 10)) into a row queue of
// QUEUE_DEPTH entries. The span output register delivers one span per cycle
// while out_pop is held, so the sustained rate is one row per cycle for disc
// rows and for ring rows with one span or none; a ring row with two spans gives
// them on successive pops. The push side takes a row every cycle while the queue
// has a free slot; a slot is held from push until the row's last span has been
// loaded for output or the row is dropped.
module disc_ring_row_span_top #(
  parameter int RADIUS_BITS = 10,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic                                in_action,
  input  logic signed [drp_pkg::COORD_W-1:0]  in_center_x,
  input  logic signed [drp_pkg::COORD_W-1:0]  in_center_y,
  input  logic        [drp_pkg::RADIUS_W-1:0] in_radius,
  input  logic        [drp_pkg::RADIUS_W-1:0] in_thickness,
  input  logic signed [drp_pkg::OFFSET_W-1:0] in_row_offset,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [drp_pkg::COORD_W-1:0]  out_span_x,
  output logic signed [drp_pkg::COORD_W-1:0]  out_span_y,
  output logic        [drp_pkg::WIDTH_W-1:0]  out_span_width,
  output logic                                out_last
);
  import drp_pkg::*;

  queue_stat_t q_stat;
  row_entry_t  q_wdata;
  row_entry_t  q_rdata;
  logic        q_alloc;
  logic        q_wr;
  logic        q_pop;
  logic [COORD_W-1:0] span_x;
  logic [COORD_W-1:0] span_y;

  drp_front #(.RADIUS_BITS(RADIUS_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_action     (in_action),
    .in_center_x   (in_center_x),
    .in_center_y   (in_center_y),
    .in_radius     (in_radius),
    .in_thickness  (in_thickness),
    .in_row_offset (in_row_offset),
    .q_stat        (q_stat),
    .q_alloc       (q_alloc),
    .q_wr          (q_wr),
    .q_wdata       (q_wdata)
  );

  drp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .alloc (q_alloc),
    .wr    (q_wr),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  drp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_span_x     (span_x),
    .out_span_y     (span_y),
    .out_span_width (out_span_width),
    .out_last       (out_last)
  );

  assign out_span_x = span_x;
  assign out_span_y = span_y;

`include "disc_ring_row_span_top_defines.svh"

  `DRP_ASSERT_NOW(a_pop_needs_row, q_pop, !q_stat.empty)
  `DRP_ASSERT_NOW(a_width_nonzero, !out_empty, out_span_width != '0)
  `DRP_ASSERT_NEXT(a_right_span_follows, out_pop && !out_empty && !out_last, !out_empty)
  `DRP_ASSERT_NEXT(a_pair_same_row, out_pop && !out_empty && !out_last,
                   out_span_y == $past(out_span_y))

endmodule

>>> bench/tb.sv
// Self-checking bench for the disc and ring row span generator.
`timescale 1ns / 1ps
module tb;
  import drp_pkg::*;

  localparam bit ROW_DISC = 1'b0;
  localparam bit ROW_RING = 1'b1;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RX_HOLD_CYCLES = 500;
  localparam int DRAIN_CYCLES = 30;
  localparam int ITEMS_PER_PHASE = 375;
  localparam int FILL_ITEMS = 80;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    bit                         action;
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic        [RADIUS_W-1:0] radius;
    logic        [RADIUS_W-1:0] thickness;
    logic signed [OFFSET_W-1:0] dy;
  } row_t;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [WIDTH_W-1:0] width;
    logic               last;
  } span_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_action = 1'b0;
  logic signed [COORD_W-1:0] in_center_x = '0;
  logic signed [COORD_W-1:0] in_center_y = '0;
  logic [RADIUS_W-1:0] in_radius = '0;
  logic [RADIUS_W-1:0] in_thickness = '0;
  logic signed [OFFSET_W-1:0] in_row_offset = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [COORD_W-1:0] out_span_x;
  logic signed [COORD_W-1:0] out_span_y;
  logic [WIDTH_W-1:0] out_span_width;
  logic out_last;

  row_t pending_rows[$];
  span_t expected_spans[$];
  span_t want_span;
  int err_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int cycle_count = 0;
  logic rx_hold_req = 1'b0;
  int rx_hold_cnt = 0;

  disc_ring_row_span_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_action      (in_action),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_radius      (in_radius),
    .in_thickness   (in_thickness),
    .in_row_offset  (in_row_offset),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_span_x     (out_span_x),
    .out_span_y     (out_span_y),
    .out_span_width (out_span_width),
    .out_last       (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int floor_root(input int v);
    int root;
    int trial;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root + (1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic void push_span(input int x, input int y, input int w, input bit last);
    span_t s;
    s.x = COORD_W'(x);
    s.y = COORD_W'(y);
    s.width = WIDTH_W'(w);
    s.last = last;
    expected_spans.push_back(s);
  endfunction

  // Append the spans that one accepted row must produce.
  function automatic void queue_row_spans(input row_t r);
    int rad, thk, dy, d2, t_out, ri, t_in, xo, xi, w, cx, y;
    rad = int'(r.radius);
    thk = int'(r.thickness);
    dy = int'(r.dy);
    cx = int'(r.cx);
    y = int'(r.cy) + dy;
    d2 = dy * dy;
    t_out = rad * rad - d2;
    if (r.action == ROW_DISC) begin
      xo = (t_out < 0) ? 0 : floor_root(t_out);
      push_span(cx - xo, y, 2 * xo + 1, 1'b1);
      return;
    end
    if (t_out < 0) return;
    xo = floor_root(t_out);
    ri = rad - thk;
    t_in = ri * ri - d2;
    if (t_in <= 0) begin
      push_span(cx - xo, y, 2 * xo + 1, 1'b1);
      return;
    end
    xi = floor_root(t_in);
    // drop rows whose inner edge lies outside the outer edge
    if (xi > xo) return;
    w = xo - xi + 1;
    push_span(cx - xo, y, w, 1'b0);
    push_span(cx + xi, y, w, 1'b1);
  endfunction

  function automatic void add_row(input bit action, input int cx, input int cy,
                                  input int rad, input int thk, input int dy);
    row_t r;
    r.action = action;
    r.cx = COORD_W'(cx);
    r.cy = COORD_W'(cy);
    r.radius = RADIUS_W'(rad);
    r.thickness = RADIUS_W'(thk);
    r.dy = OFFSET_W'(dy);
    pending_rows.push_back(r);
  endfunction

  // Mostly rows inside the radius with a sane thickness, some arbitrary ones.
  function automatic void add_random_row();
    int rad, thk, dy;
    rad = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 15))
                                      : int'($urandom_range(0, 1023));
    thk = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 1023))
                                      : int'($urandom_range(0, rad));
    dy = ($urandom_range(0, 99) < 85) ? int'($urandom_range(0, 2 * rad)) - rad
                                      : int'($urandom_range(0, 2047));
    add_row(1'($urandom_range(0, 1)), int'($urandom), int'($urandom), rad, thk, dy);
  endfunction

  task automatic wait_drained();
    while (pending_rows.size() != 0 || in_push || expected_spans.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Driver: offer the oldest pending row, hold it while the block is full.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!(in_push && in_full)) begin
      if (in_push) begin
        queue_row_spans(pending_rows[0]);
        pending_rows.delete(0);
      end
      if (pending_rows.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_push <= 1'b1;
        in_action <= pending_rows[0].action;
        in_center_x <= pending_rows[0].cx;
        in_center_y <= pending_rows[0].cy;
        in_radius <= pending_rows[0].radius;
        in_thickness <= pending_rows[0].thickness;
        in_row_offset <= pending_rows[0].dy;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk) begin
    if (rx_hold_req) begin
      rx_hold_cnt <= RX_HOLD_CYCLES;
    end else if (rx_hold_cnt != 0) begin
      rx_hold_cnt <= rx_hold_cnt - 1;
    end
  end

  // Monitor: check each popped span against the oldest expected one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_spans.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("unexpected span x=%0d y=%0d w=%0d last=%0b",
                     out_span_x, out_span_y, out_span_width, out_last);
        end else begin
          want_span = expected_spans.pop_front();
          if (out_span_x !== want_span.x || out_span_y !== want_span.y ||
              out_span_width !== want_span.width || out_last !== want_span.last) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("span mismatch: expected x=%0d y=%0d w=%0d last=%0b, got x=%0d y=%0d w=%0d last=%0b",
                       $signed(want_span.x), $signed(want_span.y), want_span.width,
                       want_span.last, out_span_x, out_span_y, out_span_width, out_last);
          end
        end
      end
      out_pop <= (rx_hold_cnt == 0) && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int tx_pct[4];
    int rx_pct[4];
    tx_pct = '{0, 69, 0, 30};
    rx_pct = '{0, 0, 69, 30};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extremes, wrap-around and each ring case
    add_row(ROW_DISC, 0, 0, 0, 0, 0);
    add_row(ROW_DISC, 100, -50, 1023, 0, 0);
    add_row(ROW_DISC, 32767, -32768, 1023, 1023, -1);
    add_row(ROW_DISC, -32768, 32767, 1023, 0, 1023);
    add_row(ROW_DISC, 5, 5, 5, 0, 10);
    add_row(ROW_DISC, 0, 0, 1023, 0, -1024);
    add_row(ROW_DISC, -1, -1, 1, 0, -1);
    add_row(ROW_RING, 0, 0, 5, 2, 10);
    add_row(ROW_RING, 0, 0, 1023, 0, -1024);
    add_row(ROW_RING, 10, 10, 20, 20, 0);
    add_row(ROW_RING, 10, 10, 20, 25, 3);
    add_row(ROW_RING, 0, 0, 10, 30, 0);
    add_row(ROW_RING, 0, 0, 10, 1023, 0);
    add_row(ROW_RING, 200, -200, 100, 10, 5);
    add_row(ROW_RING, 0, 0, 1023, 0, 0);
    add_row(ROW_RING, 32767, -32768, 1023, 1, -1);
    add_row(ROW_RING, -32768, 0, 1023, 1023, 1023);
    add_row(ROW_RING, 0, 0, 1, 0, 0);
    add_row(ROW_RING, 0, 0, 50, 49, -30);
    add_row(ROW_RING, -1, -1, 1023, 512, -700);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      tx_idle_pct = tx_pct[p];
      rx_stall_pct = rx_pct[p];
      for (int i = 0; i < ITEMS_PER_PHASE; i++) add_random_row();
      wait_drained();
      if (p == 0) begin
        // stall the output long enough for the block to fill and refuse items
        rx_hold_req = 1'b1;
        @(negedge clk);
        rx_hold_req = 1'b0;
        for (int i = 0; i < FILL_ITEMS; i++) add_random_row();
        wait_drained();
      end
    end

    if (expected_spans.size() != 0)
      $display("%0d expected spans never arrived", expected_spans.size());
    if (err_count == 0 && expected_spans.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
